### sv/pidpc_pkg.sv
// Shared types and constants of the position PID controller.
// Used by pidpc_mul, pidpc_div and pid_position_controller; depends on nothing.
package pidpc_pkg;

  localparam int MUL_AW    = 54;
  localparam int MUL_BW    = 32;
  localparam int MUL_HW    = MUL_AW + 3;
  localparam int MUL_PW    = MUL_HW + MUL_BW;
  localparam int MUL_STEPS = MUL_BW / 2;
  localparam int MUL_CW    = $clog2(MUL_STEPS);

  localparam int DIV_NW = 58;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam logic [2:0] REG_GAIN_PROP       = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEGRAL   = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV      = 3'd2;
  localparam logic [2:0] REG_DERIV_SMOOTHING = 3'd3;
  localparam logic [2:0] REG_UPPER_LIMIT     = 3'd4;
  localparam logic [2:0] REG_LOWER_LIMIT     = 3'd5;
  localparam logic [2:0] REG_DEAD_BAND       = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_DIFF_MUL,
    OP_DV_DIV,
    OP_SUM_MUL,
    OP_IV_DIV,
    OP_P_MUL,
    OP_I_MUL,
    OP_DR_MUL,
    OP_DNEW_MUL,
    OP_DOLD_MUL
  } op_t;

endpackage

### sv/pidpc_mul.sv
// Serial signed-by-unsigned multiplier, two multiplier bits per cycle.
// Depends on pidpc_pkg for its widths and step count.
module pidpc_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pidpc_pkg::MUL_AW-1:0]  a,
  input  logic        [pidpc_pkg::MUL_BW-1:0]  b,
  output logic                                 done,
  output logic signed [pidpc_pkg::MUL_PW-1:0]  prod
);
  import pidpc_pkg::*;

  logic signed [MUL_HW-1:0] hi;
  logic        [MUL_BW-1:0] lo;
  logic signed [MUL_HW-1:0] a1;
  logic signed [MUL_HW-1:0] a3;
  logic signed [MUL_HW-1:0] a_ext;
  logic signed [MUL_HW-1:0] addend;
  logic signed [MUL_HW-1:0] sum;
  logic signed [MUL_PW-1:0] shifted;
  logic        [MUL_CW-1:0] cnt;
  logic                     busy;

  always_comb begin
    a_ext = MUL_HW'(a);
    case (lo[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = a1;
      2'd2:    addend = a1 <<< 1;
      default: addend = a3;
    endcase
    sum     = hi + addend;
    shifted = $signed({sum, lo}) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= '0;
      lo  <= b;
      a1  <= a_ext;
      a3  <= a_ext + (a_ext <<< 1);
      cnt <= MUL_CW'(MUL_STEPS - 1);
    end else if (busy) begin
      {hi, lo} <= shifted;
      cnt      <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  assign prod = {hi, lo};

endmodule

### sv/pidpc_div.sv
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on pidpc_pkg for its widths and step count.
module pidpc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidpc_pkg::DIV_NW-1:0]  num,
  input  logic [pidpc_pkg::DIV_DW-1:0]  den,
  output logic                          done,
  output logic [pidpc_pkg::DIV_NW-1:0]  quot
);
  import pidpc_pkg::*;

  logic [DIV_NW-1:0] dvd;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   trial;
  logic [DIV_CW-1:0] cnt;
  logic              busy;

  assign trial = {rem, dvd[DIV_NW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= num;
      rem <= '0;
      dsr <= den;
      cnt <= DIV_CW'(DIV_NW - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (!trial[DIV_DW]) begin
        rem <= trial[DIV_DW-1:0];
        dvd <= {dvd[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_DW-2:0], dvd[DIV_NW-1]};
        dvd <= {dvd[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = dvd;

endmodule

### sv/pid_position_controller.sv
// Position PID controller with filtered derivative, top level.
// Depends on pidpc_pkg, pidpc_mul and pidpc_div.
//
// A sample with a valid target, when a previous sample exists, takes seven
// multiplications on the shared two-bit serial multiplier and two divisions on
// the one-bit serial divider, besides the steps that accept and finish it.
// The first sample after a clear takes only the five multiplications, and a
// sample with an invalid target goes from accept straight to finish. The
// block takes one sample at a time; the result waits in an output register
// while the next sample is accepted.
module pid_position_controller #(
  parameter int GAIN_FRAC_BITS   = 16,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // setpoint, measured, time_us
  input  logic [0:0]  s_axis_tuser,   // target_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // drive
  output logic [0:0]  m_axis_tuser,   // in_dead_band
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import pidpc_pkg::*;

  localparam logic [MUL_BW-1:0] TICKS     = MUL_BW'(TICKS_PER_SECOND);
  localparam logic [DIV_DW-1:0] TWO_TICKS = DIV_DW'(2 * TICKS_PER_SECOND);

  logic        [23:0] gain_prop;
  logic        [23:0] gain_integral;
  logic        [23:0] gain_deriv;
  logic        [15:0] deriv_smoothing;
  logic signed [23:0] upper_limit;
  logic signed [23:0] lower_limit;
  logic        [22:0] dead_band;

  logic signed [24:0] last_error;
  logic signed [23:0] error_integral;
  logic signed [31:0] last_deriv_term;
  logic        [31:0] last_time;
  logic               have_previous;

  state_t state, state_next;
  op_t    op, op_next;

  logic signed [24:0]        e_reg;
  logic        [31:0]        el_reg;
  logic        [31:0]        now_reg;
  logic                      tv_reg;
  logic        [DIV_NW-1:0]  num_reg;
  logic                      num_neg;
  logic signed [MUL_AW-1:0]  dv;
  logic signed [31:0]        iv;
  logic signed [63:0]        acc;
  logic signed [31:0]        dr;
  logic signed [63:0]        dacc;
  logic signed [31:0]        d_reg;

  logic                      mul_start, div_start, mul_done, div_done, unit_done, is_div;
  logic signed [MUL_AW-1:0]  mul_a;
  logic        [MUL_BW-1:0]  mul_b;
  logic signed [MUL_PW-1:0]  prod;
  logic        [DIV_NW-1:0]  div_n;
  logic        [DIV_DW-1:0]  div_d;
  logic        [DIV_NW-1:0]  quot;

  logic signed [24:0]        e_in;
  logic        [31:0]        el_in;
  logic signed [25:0]        e_diff, e_sum;
  logic signed [MUL_PW-1:0]  prod_sh, prod_mag;
  logic signed [63:0]        q_signed, iv_wide;
  logic signed [31:0]        iv_sat, dr_sat;
  logic signed [63:0]        d_sum, total, clamp1, clamp2;
  logic signed [31:0]        ei1, ei2;
  logic        [24:0]        e_mag;
  logic                      in_db, out_free, finish;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= 24'd5898;
      gain_integral   <= '0;
      gain_deriv      <= '0;
      deriv_smoothing <= '0;
      upper_limit     <= 24'sd30720;
      lower_limit     <= -24'sd30720;
      dead_band       <= 23'd512;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_PROP:       gain_prop       <= cfg_data;
        REG_GAIN_INTEGRAL:   gain_integral   <= cfg_data;
        REG_GAIN_DERIV:      gain_deriv      <= cfg_data;
        REG_DERIV_SMOOTHING: deriv_smoothing <= cfg_data[15:0];
        REG_UPPER_LIMIT:     upper_limit     <= $signed(cfg_data);
        REG_LOWER_LIMIT:     lower_limit     <= $signed(cfg_data);
        REG_DEAD_BAND:       dead_band       <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  assign is_div    = (op == OP_DV_DIV) || (op == OP_IV_DIV);
  assign unit_done = is_div ? div_done : mul_done;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = s_axis_tuser[0] ? ST_ISSUE : ST_FINISH;
          op_next    = have_previous ? OP_DIFF_MUL : OP_P_MUL;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (unit_done) begin
          state_next = ST_ISSUE;
          case (op)
            OP_DIFF_MUL: op_next = OP_DV_DIV;
            OP_DV_DIV:   op_next = OP_SUM_MUL;
            OP_SUM_MUL:  op_next = OP_IV_DIV;
            OP_IV_DIV:   op_next = OP_P_MUL;
            OP_P_MUL:    op_next = OP_I_MUL;
            OP_I_MUL:    op_next = OP_DR_MUL;
            OP_DR_MUL:   op_next = OP_DNEW_MUL;
            OP_DNEW_MUL: op_next = OP_DOLD_MUL;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    finish        = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_ISSUE: begin
        mul_start = !is_div;
        div_start = is_div;
      end
      ST_WAIT:   ;
      ST_FINISH: finish = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_P_MUL;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    e_in   = 25'($signed(s_axis_tdata[23:0])) - 25'($signed(s_axis_tdata[47:24]));
    el_in  = s_axis_tdata[79:48] - last_time;
    e_diff = 26'(e_reg) - 26'(last_error);
    e_sum  = 26'(e_reg) + 26'(last_error);
    mul_a  = '0;
    mul_b  = '0;
    div_n  = num_reg;
    div_d  = el_reg;
    case (op)
      OP_DIFF_MUL: begin
        mul_a = MUL_AW'(e_diff);
        mul_b = TICKS;
      end
      OP_SUM_MUL: begin
        mul_a = MUL_AW'(e_sum);
        mul_b = el_reg;
      end
      OP_IV_DIV: div_d = TWO_TICKS;
      OP_P_MUL: begin
        mul_a = MUL_AW'(e_reg);
        mul_b = MUL_BW'(gain_prop);
      end
      OP_I_MUL: begin
        mul_a = MUL_AW'(iv);
        mul_b = MUL_BW'(gain_integral);
      end
      OP_DR_MUL: begin
        mul_a = dv;
        mul_b = MUL_BW'(gain_deriv);
      end
      OP_DNEW_MUL: begin
        mul_a = MUL_AW'(dr);
        mul_b = MUL_BW'(17'h10000 - {1'b0, deriv_smoothing});
      end
      OP_DOLD_MUL: begin
        mul_a = MUL_AW'(last_deriv_term);
        mul_b = MUL_BW'(deriv_smoothing);
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_sh  = prod >>> GAIN_FRAC_BITS;
    prod_mag = prod[MUL_PW-1] ? -prod : prod;
    q_signed = num_neg ? -$signed(64'(quot)) : $signed(64'(quot));
    iv_wide  = 64'(error_integral) + q_signed;
    if (iv_wide > 64'sd2147483647) begin
      iv_sat = 32'sh7fffffff;
    end else if (iv_wide < -64'sd2147483648) begin
      iv_sat = 32'sh80000000;
    end else begin
      iv_sat = iv_wide[31:0];
    end
    if (prod_sh > MUL_PW'(64'sd2147483647)) begin
      dr_sat = 32'sh7fffffff;
    end else if (prod_sh < MUL_PW'(-64'sd2147483648)) begin
      dr_sat = 32'sh80000000;
    end else begin
      dr_sat = prod_sh[31:0];
    end
    d_sum  = dacc + prod[63:0];
    total  = acc + 64'(d_reg);
    clamp1 = (total > 64'(upper_limit)) ? 64'(upper_limit) : total;
    clamp2 = (clamp1 < 64'(lower_limit)) ? 64'(lower_limit) : clamp1;
    ei1    = (iv > 32'(upper_limit)) ? 32'(upper_limit) : iv;
    ei2    = (ei1 < 32'(lower_limit)) ? 32'(lower_limit) : ei1;
    e_mag  = e_reg[24] ? 25'(-e_reg) : 25'(e_reg);
    in_db  = e_mag <= {2'b00, dead_band};
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      e_reg   <= e_in;
      el_reg  <= (el_in == '0) ? 32'd1 : el_in;
      now_reg <= s_axis_tdata[79:48];
      tv_reg  <= s_axis_tuser[0];
      dv      <= '0;
      iv      <= '0;
    end else if ((state == ST_WAIT) && unit_done) begin
      case (op)
        OP_DIFF_MUL, OP_SUM_MUL: begin
          num_reg <= prod_mag[DIV_NW-1:0];
          num_neg <= prod[MUL_PW-1];
        end
        OP_DV_DIV:   dv    <= num_neg ? -$signed(quot[MUL_AW-1:0]) : $signed(quot[MUL_AW-1:0]);
        OP_IV_DIV:   iv    <= iv_sat;
        OP_P_MUL:    acc   <= prod_sh[63:0];
        OP_I_MUL:    acc   <= acc + prod_sh[63:0];
        OP_DR_MUL:   dr    <= dr_sat;
        OP_DNEW_MUL: dacc  <= prod[63:0];
        OP_DOLD_MUL: d_reg <= d_sum[47:16];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error      <= '0;
      error_integral  <= '0;
      last_deriv_term <= '0;
      last_time       <= '0;
      have_previous   <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
      if (tv_reg) begin
        last_error      <= e_reg;
        error_integral  <= ei2[23:0];
        last_deriv_term <= d_reg;
        last_time       <= now_reg;
        have_previous   <= 1'b1;
      end else begin
        last_error      <= '0;
        error_integral  <= '0;
        last_deriv_term <= '0;
        last_time       <= '0;
        have_previous   <= 1'b0;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (tv_reg && !in_db) begin
        m_axis_tdata <= clamp2[23:0];
        m_axis_tuser <= 1'b0;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b1;
      end
    end
  end

  pidpc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pidpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quot  (quot)
  );

endmodule
